### design/osf_pkg.sv
// Shared types, constants and saturation helpers for the observer state feedback step unit
`default_nettype none
package osf_pkg;

    localparam int COEF_W    = 16;
    localparam int DATA_W    = 32;
    localparam int MUL_A_W   = COEF_W + 1;
    localparam int PROD_W    = MUL_A_W + DATA_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int MAG_W     = PROD_W - 1;
    localparam int DT_W      = 16;
    localparam int EST_COUNT = 4;
    localparam int IDX_W     = $clog2(EST_COUNT);
    localparam int MS_PER_S  = 1000;
    localparam int REM_W     = 10;
    localparam int DIGIT_W   = 8;
    localparam int DIV_STEPS = MAG_W / DIGIT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int FRAC_SH   = 8;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic [3:0] t_coef_sel;
    localparam t_coef_sel COEF_K0    = 4'd0;
    localparam t_coef_sel COEF_K1    = 4'd1;
    localparam t_coef_sel COEF_K2    = 4'd2;
    localparam t_coef_sel COEF_C0    = 4'd3;
    localparam t_coef_sel COEF_C1    = 4'd4;
    localparam t_coef_sel COEF_A00   = 4'd5;
    localparam t_coef_sel COEF_A01   = 4'd6;
    localparam t_coef_sel COEF_A10   = 4'd7;
    localparam t_coef_sel COEF_A11   = 4'd8;
    localparam t_coef_sel COEF_B0    = 4'd9;
    localparam t_coef_sel COEF_B1    = 4'd10;
    localparam t_coef_sel COEF_B2    = 4'd11;
    localparam t_coef_sel COEF_L0    = 4'd12;
    localparam t_coef_sel COEF_L1    = 4'd13;
    localparam t_coef_sel COEF_DT    = 4'd14;
    localparam t_coef_sel COEF_SCALE = 4'd15;

    typedef logic [2:0] t_opnd_sel;
    localparam t_opnd_sel OPND_X0 = 3'd0;
    localparam t_opnd_sel OPND_X1 = 3'd1;
    localparam t_opnd_sel OPND_X2 = 3'd2;
    localparam t_opnd_sel OPND_X3 = 3'd3;
    localparam t_opnd_sel OPND_U  = 3'd4;
    localparam t_opnd_sel OPND_YD = 3'd5;
    localparam t_opnd_sel OPND_D  = 3'd6;

    typedef logic [1:0] t_fin;
    localparam t_fin FIN_NONE = 2'd0;
    localparam t_fin FIN_U    = 2'd1;
    localparam t_fin FIN_YD   = 2'd2;
    localparam t_fin FIN_D    = 2'd3;

    typedef struct packed {
        logic [47:0] feedback_gains;
        logic [31:0] observer_gains;
        logic [31:0] output_weights;
        logic [63:0] plant_matrix;
        logic [47:0] input_vector;
        logic [15:0] set_point;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic             load;
        logic             mul;
        logic             acc;
        logic             acc_clr;
        t_coef_sel        coef_sel;
        t_opnd_sel        opnd_sel;
        t_fin             fin;
        logic             div_start;
        logic             upd;
        logic [IDX_W-1:0] upd_idx;
        logic             done;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

    function automatic logic signed [MUL_A_W-1:0] coef17(input logic [COEF_W-1:0] v);
        return {v[COEF_W-1], v};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] hi;
        hi = v[ACC_W-1:DATA_W-1];
        if ((&hi) || (~|hi)) begin
            return v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7fff_ffff;
        end
    endfunction

endpackage
`default_nettype wire

### design/osf_div1000.sv
// Signed divide by 1000 truncating toward zero, eight quotient bits per cycle
`default_nettype none
module osf_div1000 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [osf_pkg::PROD_W-1:0] i_dividend,
    output logic                              o_done,
    output logic signed [osf_pkg::PROD_W-1:0] o_quotient
);
    import osf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [MAG_W-1:0]     r_mag;
    logic [MAG_W-1:0]     r_quo;
    logic [REM_W-1:0]     r_rem;
    logic                 r_neg;
    logic [PROD_W-1:0]    w_abs;
    logic [REM_W-1:0]     w_rem;
    logic [DIGIT_W-1:0]   w_qbyte;

    assign w_abs = i_dividend[PROD_W-1] ? (-i_dividend) : i_dividend;

    always_comb begin
        logic [REM_W-1:0] rem;
        logic [REM_W:0]   trial;
        rem     = r_rem;
        w_qbyte = '0;
        for (int k = 0; k < DIGIT_W; k++) begin
            trial = {rem, r_mag[MAG_W-1-k]};
            if (trial >= (REM_W+1)'(MS_PER_S)) begin
                trial                  = trial - (REM_W+1)'(MS_PER_S);
                w_qbyte[DIGIT_W-1-k]   = 1'b1;
            end
            rem = trial[REM_W-1:0];
        end
        w_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= w_abs[MAG_W-1:0];
            r_neg <= i_dividend[PROD_W-1];
            r_rem <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[MAG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            r_rem <= w_rem;
            r_quo <= {r_quo[MAG_W-DIGIT_W-1:0], w_qbyte};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (-$signed({1'b0, r_quo})) : $signed({1'b0, r_quo});

endmodule
`default_nettype wire

### design/osf_dpath.sv
// Datapath: coefficient and operand select, shared multiplier, accumulator, estimates
`default_nettype none
module osf_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  osf_pkg::t_cfg                     i_cfg,
    input  osf_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [15:0]                i_angle,
    input  logic [31:0]                       i_time_ms,
    output osf_pkg::t_dp_sts                  o_sts,
    output logic signed [osf_pkg::DATA_W-1:0] o_drive
);
    import osf_pkg::*;

    logic signed [DATA_W-1:0]  r_est [EST_COUNT];
    logic [DATA_W-1:0]         r_last_time;
    logic                      r_pend;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [15:0]        r_angle;
    logic [DT_W-1:0]           r_dt;
    logic signed [DATA_W-1:0]  r_u;
    logic signed [DATA_W-1:0]  r_yd;
    logic signed [DATA_W-1:0]  r_d;
    logic signed [DATA_W-1:0]  r_drive;

    logic signed [MUL_A_W-1:0] w_coef;
    logic signed [DATA_W-1:0]  w_opnd;
    logic signed [PROD_W-1:0]  w_prod;
    logic [DATA_W-1:0]         w_elapsed;
    logic [DT_W-1:0]           w_dt;
    logic signed [ACC_W-1:0]   w_neg_acc;
    logic signed [MUL_A_W-1:0] w_err;
    logic signed [ACC_W-1:0]   w_yd_full;
    logic signed [PROD_W-1:0]  w_quo;
    logic                      w_div_done;
    logic signed [DATA_W-1:0]  w_upd;

    always_comb begin
        unique case (i_cmd.coef_sel)
            COEF_K0:    w_coef = coef17(i_cfg.feedback_gains[15:0]);
            COEF_K1:    w_coef = coef17(i_cfg.feedback_gains[31:16]);
            COEF_K2:    w_coef = coef17(i_cfg.feedback_gains[47:32]);
            COEF_C0:    w_coef = coef17(i_cfg.output_weights[15:0]);
            COEF_C1:    w_coef = coef17(i_cfg.output_weights[31:16]);
            COEF_A00:   w_coef = coef17(i_cfg.plant_matrix[15:0]);
            COEF_A01:   w_coef = coef17(i_cfg.plant_matrix[31:16]);
            COEF_A10:   w_coef = coef17(i_cfg.plant_matrix[47:32]);
            COEF_A11:   w_coef = coef17(i_cfg.plant_matrix[63:48]);
            COEF_B0:    w_coef = coef17(i_cfg.input_vector[15:0]);
            COEF_B1:    w_coef = coef17(i_cfg.input_vector[31:16]);
            COEF_B2:    w_coef = coef17(i_cfg.input_vector[47:32]);
            COEF_L0:    w_coef = coef17(i_cfg.observer_gains[15:0]);
            COEF_L1:    w_coef = coef17(i_cfg.observer_gains[31:16]);
            COEF_DT:    w_coef = $signed({1'b0, r_dt});
            COEF_SCALE: w_coef = MUL_A_W'(1 << FRAC_SH);
            default:    w_coef = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.opnd_sel)
            OPND_X0: w_opnd = r_est[0];
            OPND_X1: w_opnd = r_est[1];
            OPND_X2: w_opnd = r_est[2];
            OPND_X3: w_opnd = r_est[3];
            OPND_U:  w_opnd = r_u;
            OPND_YD: w_opnd = r_yd;
            OPND_D:  w_opnd = r_d;
            default: w_opnd = '0;
        endcase
    end

    assign w_prod    = PROD_W'(w_coef) * PROD_W'(w_opnd);
    assign w_elapsed = i_time_ms - r_last_time;
    assign w_dt      = (|w_elapsed[DATA_W-1:DT_W]) ? {DT_W{1'b1}} : w_elapsed[DT_W-1:0];
    assign w_neg_acc = -r_acc;
    assign w_err     = coef17(r_angle) - coef17(i_cfg.set_point);
    assign w_yd_full = (ACC_W'(w_err) <<< FRAC_SH) - (r_acc >>> FRAC_SH);
    assign w_upd     = sat32(ACC_W'(w_opnd) + ACC_W'(w_quo));

    osf_div1000 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est       <= '{default: '0};
            r_last_time <= '0;
            r_pend      <= 1'b0;
        end else begin
            r_pend <= i_cmd.mul & i_cmd.acc;
            if (i_cmd.start) begin
                r_est       <= '{default: '0};
                r_last_time <= i_time_ms;
            end
            if (i_cmd.load) begin
                r_last_time <= i_time_ms;
            end
            if (i_cmd.upd) begin
                r_est[i_cmd.upd_idx] <= w_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_pend) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.load) begin
            r_angle <= i_angle;
            r_dt    <= w_dt;
        end
        unique case (i_cmd.fin)
            FIN_U:    r_u  <= sat32(w_neg_acc >>> FRAC_SH);
            FIN_YD:   r_yd <= sat32(w_yd_full);
            FIN_D:    r_d  <= sat32(r_acc >>> FRAC_SH);
            default: begin
            end
        endcase
        if (i_cmd.start) begin
            r_drive <= '0;
        end else if (i_cmd.done) begin
            r_drive <= r_u;
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_drive        = r_drive;

endmodule
`default_nettype wire

### design/osf_ctrl.sv
// Controller: sequences the multiply-accumulate sums, divides and estimate updates
`default_nettype none
module osf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_operation,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_out_ready,
    input  osf_pkg::t_dp_sts  i_sts,
    output osf_pkg::t_dp_cmd  o_cmd
);
    import osf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SUM    = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_FIN    = 3'd3;
    localparam logic [2:0] S_DT     = 3'd4;
    localparam logic [2:0] S_DSTART = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;

    localparam logic [2:0] SUM_U  = 3'd0;
    localparam logic [2:0] SUM_YD = 3'd1;
    localparam logic [2:0] SUM_X0 = 3'd2;
    localparam logic [2:0] SUM_X1 = 3'd3;
    localparam logic [2:0] SUM_X2 = 3'd4;
    localparam logic [2:0] SUM_X3 = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_sum, n_sum;
    logic [1:0]       r_term, n_term;
    logic             r_out_valid, n_out_valid;
    logic             w_take;
    logic [IDX_W-1:0] w_xidx;

    function automatic logic [1:0] term_last(input logic [2:0] sum);
        unique case (sum)
            SUM_U:          return 2'd2;
            SUM_YD:         return 2'd1;
            SUM_X0, SUM_X1: return 2'd3;
            default:        return 2'd0;
        endcase
    endfunction

    function automatic t_coef_sel term_coef(input logic [2:0] sum, input logic [1:0] term);
        t_coef_sel c;
        c = COEF_SCALE;
        unique case (sum)
            SUM_U: begin
                unique case (term)
                    2'd0:    c = COEF_K0;
                    2'd1:    c = COEF_K1;
                    default: c = COEF_K2;
                endcase
            end
            SUM_YD: c = (term == 2'd0) ? COEF_C0 : COEF_C1;
            SUM_X0: begin
                unique case (term)
                    2'd0:    c = COEF_A00;
                    2'd1:    c = COEF_A01;
                    2'd2:    c = COEF_B0;
                    default: c = COEF_L0;
                endcase
            end
            SUM_X1: begin
                unique case (term)
                    2'd0:    c = COEF_A10;
                    2'd1:    c = COEF_A11;
                    2'd2:    c = COEF_B1;
                    default: c = COEF_L1;
                endcase
            end
            SUM_X2:  c = COEF_B2;
            default: c = COEF_SCALE;
        endcase
        return c;
    endfunction

    function automatic t_opnd_sel term_opnd(input logic [2:0] sum, input logic [1:0] term);
        t_opnd_sel o;
        o = OPND_X2;
        unique case (sum)
            SUM_X2: o = OPND_U;
            SUM_X3: o = OPND_X2;
            default: begin
                unique case (term)
                    2'd0:    o = OPND_X0;
                    2'd1:    o = OPND_X1;
                    2'd2:    o = (sum == SUM_U) ? OPND_X2 : OPND_U;
                    default: o = OPND_YD;
                endcase
            end
        endcase
        return o;
    endfunction

    function automatic t_opnd_sel est_opnd(input logic [IDX_W-1:0] idx);
        unique case (idx)
            2'd0:    return OPND_X0;
            2'd1:    return OPND_X1;
            2'd2:    return OPND_X2;
            default: return OPND_X3;
        endcase
    endfunction

    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_valid = r_out_valid;
    assign w_take  = i_valid && o_ready;
    assign w_xidx  = IDX_W'(r_sum - SUM_X0);

    always_comb begin
        n_state          = r_state;
        n_sum            = r_sum;
        n_term           = r_term;
        n_out_valid      = r_out_valid & ~i_out_ready;
        o_cmd            = '0;
        o_cmd.coef_sel   = term_coef(r_sum, r_term);
        o_cmd.opnd_sel   = term_opnd(r_sum, r_term);
        o_cmd.fin        = FIN_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (i_operation == OP_START) begin
                        o_cmd.start = 1'b1;
                        n_out_valid = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_sum      = SUM_U;
                        n_term     = '0;
                        n_state    = S_SUM;
                    end
                end
            end
            S_SUM: begin
                o_cmd.mul     = 1'b1;
                o_cmd.acc     = 1'b1;
                o_cmd.acc_clr = (r_term == 2'd0);
                if (r_term == term_last(r_sum)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_term = r_term + 2'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_term = '0;
                priority if (r_sum == SUM_U) begin
                    o_cmd.fin = FIN_U;
                    n_sum     = SUM_YD;
                    n_state   = S_SUM;
                end else if (r_sum == SUM_YD) begin
                    o_cmd.fin = FIN_YD;
                    n_sum     = SUM_X0;
                    n_state   = S_SUM;
                end else begin
                    o_cmd.fin = FIN_D;
                    n_state   = S_DT;
                end
            end
            S_DT: begin
                o_cmd.mul      = 1'b1;
                o_cmd.coef_sel = COEF_DT;
                o_cmd.opnd_sel = OPND_D;
                n_state        = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.opnd_sel = est_opnd(w_xidx);
                o_cmd.upd_idx  = w_xidx;
                if (i_sts.div_done) begin
                    o_cmd.upd = 1'b1;
                    if (r_sum == SUM_X3) begin
                        o_cmd.done  = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_sum   = r_sum + 3'd1;
                        n_state = S_SUM;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= SUM_U;
            r_term      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_term      <= n_term;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

### design/observer_state_feedback_step_unit.sv
// Top level: register port, controller and datapath of the observer state feedback step unit
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_operation, i_angle, i_time_ms
//   output   out        o_valid / i_ready    o_drive
//   config   in         psel/penable/pwrite  paddr (8-byte regs), pwdata, prdata, pready
//
// A start item gives a valid result in the cycle after it is accepted.
// A control item runs one shared 17x32 multiplier over 19 products in sequence (15 sum
// terms, 4 time steps), and each of the four estimate updates starts the divide by 1000
// and waits for its quotient.
// One item is worked on at a time; a new item is taken once the result is taken or
// is being taken. A stalled output holds its item. Reset is synchronous, active low.
`default_nettype none
module observer_state_feedback_step_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_operation,
    input  logic signed [15:0] i_angle,
    input  logic [31:0]        i_time_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_drive,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import osf_pkg::*;

    localparam logic [2:0] REG_FEEDBACK_GAINS = 3'd0;
    localparam logic [2:0] REG_OBSERVER_GAINS = 3'd1;
    localparam logic [2:0] REG_OUTPUT_WEIGHTS = 3'd2;
    localparam logic [2:0] REG_PLANT_MATRIX   = 3'd3;
    localparam logic [2:0] REG_INPUT_VECTOR   = 3'd4;
    localparam logic [2:0] REG_SET_POINT      = 3'd5;

    t_cfg       r_cfg;
    t_dp_cmd    w_cmd;
    t_dp_sts    w_sts;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FEEDBACK_GAINS: r_cfg.feedback_gains <= pwdata[47:0];
                REG_OBSERVER_GAINS: r_cfg.observer_gains <= pwdata[31:0];
                REG_OUTPUT_WEIGHTS: r_cfg.output_weights <= pwdata[31:0];
                REG_PLANT_MATRIX:   r_cfg.plant_matrix   <= pwdata;
                REG_INPUT_VECTOR:   r_cfg.input_vector   <= pwdata[47:0];
                REG_SET_POINT:      r_cfg.set_point      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FEEDBACK_GAINS: prdata = {16'h0000, r_cfg.feedback_gains};
            REG_OBSERVER_GAINS: prdata = {32'h0000_0000, r_cfg.observer_gains};
            REG_OUTPUT_WEIGHTS: prdata = {32'h0000_0000, r_cfg.output_weights};
            REG_PLANT_MATRIX:   prdata = r_cfg.plant_matrix;
            REG_INPUT_VECTOR:   prdata = {16'h0000, r_cfg.input_vector};
            REG_SET_POINT:      prdata = {48'h0000_0000_0000, r_cfg.set_point};
            default:            prdata = '0;
        endcase
    end

    osf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    osf_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (w_cmd),
        .i_angle   (i_angle),
        .i_time_ms (i_time_ms),
        .o_sts     (w_sts),
        .o_drive   (o_drive)
    );

endmodule
`default_nettype wire

### verif/observer_state_feedback_step_unit_tb.sv
// Testbench for the observer state feedback step unit: predicts each drive and checks it
module observer_state_feedback_step_unit_tb;
    import osf_pkg::*;

    localparam int REG_FEEDBACK = 0;
    localparam int REG_OBSERVER = 1;
    localparam int REG_OUTPUT   = 2;
    localparam int REG_PLANT    = 3;
    localparam int REG_INPUT    = 4;
    localparam int REG_SETPOINT = 5;
    localparam int REG_COUNT    = 6;
    localparam int REG_WIDTH [REG_COUNT] = '{48, 32, 32, 64, 48, 16};

    localparam logic [31:0] DT_LIMIT = 32'd65535;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef enum int {CFG_ZERO, CFG_TAME, CFG_MAX, CFG_MIN, CFG_WILD} t_cfg_kind;

    localparam int PHASES = 10;
    localparam t_cfg_kind PHASE_KIND [PHASES] = '{CFG_TAME, CFG_MAX, CFG_TAME, CFG_MIN,
        CFG_WILD, CFG_TAME, CFG_ZERO, CFG_WILD, CFG_TAME, CFG_TAME};
    localparam int TX_IDLE  [4] = '{0, 47, 0, 38};
    localparam int RX_STALL [4] = '{0, 0, 47, 38};

    class drive_tracker;
        logic [63:0] regs [REG_COUNT] = '{default: '0};
        int          est [EST_COUNT];
        logic [31:0] last_ms = '0;
        int          expected_drive [$];
        int          errors;

        static function longint coef(logic [63:0] word, int slot);
            return longint'($signed(word[16*slot +: 16]));
        endfunction

        static function int clamp32(longint v);
            if (v > SAT_HI) begin
                return int'(SAT_HI);
            end
            if (v < SAT_LO) begin
                return int'(SAT_LO);
            end
            return int'(v);
        endfunction

        static function int euler_step(int x, longint deriv, longint dt);
            longint d;
            longint inc;
            d   = clamp32(deriv >>> 8);
            inc = (d * dt) / MS_PER_S;
            return clamp32(longint'(x) + inc);
        endfunction

        function void set_reg(int idx, logic [63:0] word);
            if (idx < REG_COUNT) begin
                regs[idx] = word & ((64'd1 << REG_WIDTH[idx]) - 64'd1);
            end
        endfunction

        function void accept_sample(logic op, logic [15:0] ang, logic [31:0] t_ms);
            logic [31:0] el;
            longint dt, x0, x1, x2, u, yd, err;
            if (op == OP_START) begin
                last_ms = t_ms;
                foreach (est[i]) est[i] = 0;
                expected_drive.push_back(0);
                return;
            end
            el = t_ms - last_ms;
            dt = (el > DT_LIMIT) ? DT_LIMIT : el;
            x0 = est[0];
            x1 = est[1];
            x2 = est[2];
            u = clamp32((-(coef(regs[REG_FEEDBACK], 0) * x0 + coef(regs[REG_FEEDBACK], 1) * x1
                           + coef(regs[REG_FEEDBACK], 2) * x2)) >>> 8);
            err = longint'($signed(ang)) - coef(regs[REG_SETPOINT], 0);
            yd = clamp32(err * 256
                         - ((coef(regs[REG_OUTPUT], 0) * x0
                             + coef(regs[REG_OUTPUT], 1) * x1) >>> 8));
            est[0] = euler_step(est[0],
                coef(regs[REG_PLANT], 0) * longint'(est[0])
                + coef(regs[REG_PLANT], 1) * longint'(est[1])
                + coef(regs[REG_INPUT], 0) * u + coef(regs[REG_OBSERVER], 0) * yd, dt);
            est[1] = euler_step(est[1],
                coef(regs[REG_PLANT], 2) * longint'(est[0])
                + coef(regs[REG_PLANT], 3) * longint'(est[1])
                + coef(regs[REG_INPUT], 1) * u + coef(regs[REG_OBSERVER], 1) * yd, dt);
            est[2] = euler_step(est[2], coef(regs[REG_INPUT], 2) * u, dt);
            est[3] = euler_step(est[3], longint'(est[2]) * 256, dt);
            last_ms = t_ms;
            expected_drive.push_back(int'(u));
        endfunction

        function void check_drive(logic signed [31:0] got);
            int want;
            if (expected_drive.size() == 0) begin
                errors++;
                $display("%0t: drive %0d arrived with no item pending", $time, got);
                return;
            end
            want = expected_drive.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: drive mismatch: expected %0d, actual %0d", $time, want, got);
            end
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_operation;
    logic signed [15:0] i_angle;
    logic [31:0]        i_time_ms;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_drive;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [5:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    int tx_idle_pct;
    int rx_stall_pct;

    drive_tracker tracker = new();

    observer_state_feedback_step_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_angle     (i_angle),
        .i_time_ms   (i_time_ms),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_drive     (o_drive),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] cfg_word(t_cfg_kind kind);
        logic [63:0] word;
        for (int s = 0; s < 4; s++) begin
            case (kind)
                CFG_ZERO: word[16*s +: 16] = 16'h0000;
                CFG_MAX:  word[16*s +: 16] = 16'h7fff;
                CFG_MIN:  word[16*s +: 16] = 16'h8000;
                CFG_TAME: word[16*s +: 16] = 16'($urandom_range(1024) - 512);
                default:  word[16*s +: 16] = 16'($urandom);
            endcase
        end
        return word;
    endfunction

    function automatic logic [15:0] rand_angle();
        if ($urandom_range(9) < 7) begin
            return 16'($urandom_range(2048) - 1024);
        end
        return 16'($urandom);
    endfunction

    task automatic send_item(input logic op, input logic [15:0] ang, input logic [31:0] t_ms);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_angle     <= ang;
        i_time_ms   <= t_ms;
        do @(posedge i_clk); while (!o_ready);
        tracker.accept_sample(op, ang, t_ms);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input int idx, input logic [63:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx * 8);
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, word);
    endtask

    task automatic load_config(input t_cfg_kind kind);
        for (int idx = 0; idx < REG_COUNT; idx++) begin
            reg_write(idx, cfg_word(kind));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic directed_burst();
        send_item(OP_STEP, 16'h7fff, 32'd7);
        send_item(OP_STEP, 16'h8000, 32'hffff_ffff);
        send_item(OP_START, 16'h0000, 32'hffff_fff0);
        send_item(OP_STEP, 16'h0100, 32'h0000_0010);
        send_item(OP_STEP, 16'h8000, 32'h0000_0010);
        send_item(OP_STEP, 16'h7fff, 32'h0000_0010 + 32'd65535);
        send_item(OP_STEP, 16'hffff, 32'h0000_0010 + 32'd65535 + 32'd65536);
    endtask

    task automatic run_random(input int quota);
        int          sent;
        int          steps;
        logic [31:0] now_ms;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(99) < 85) begin
                now_ms = ($urandom_range(3) == 0) ? 32'hffff_ffff - $urandom_range(300)
                                                  : $urandom;
                send_item(OP_START, rand_angle(), now_ms);
                steps = $urandom_range(12, 3);
                repeat (steps) begin
                    now_ms += $urandom_range(60, 0);
                    send_item(OP_STEP, rand_angle(), now_ms);
                end
                sent += steps + 1;
            end else begin
                send_item(1'($urandom_range(1)), 16'($urandom), $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_ready && o_valid) begin
                tracker.check_drive(o_drive);
            end
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= OP_START;
        i_angle     <= '0;
        i_time_ms   <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_burst();
        settle();
        load_config(CFG_MAX);
        directed_burst();
        settle();
        load_config(CFG_MIN);
        directed_burst();

        for (int p = 0; p < PHASES; p++) begin
            settle();
            load_config(PHASE_KIND[p]);
            tx_idle_pct  = TX_IDLE[p % 4];
            rx_stall_pct = RX_STALL[p % 4];
            run_random(125);
        end

        settle();
        repeat (100) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
